FILE: rtl/lmks_pkg.sv
// Package for the lexicographic minimum key select block.
// Item and result types, compare status codes and default sizes.
// No dependencies.
`default_nettype none

package lmks_pkg;

	localparam int MAX_KEY_LEN_DEF = 32;
	localparam int MAX_ENTRIES_DEF = 65536;

	localparam int MIN_INDEX_W = 17;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;

	localparam logic [1:0] CMP_EQUAL   = 2'd0;
	localparam logic [1:0] CMP_LESS    = 2'd1;
	localparam logic [1:0] CMP_GREATER = 2'd2;

	typedef logic [MIN_INDEX_W-1:0] min_index_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] key_byte;
		logic       end_of_string;
		logic       missing_entry;
		logic       end_of_set;
	} item_t;

	typedef struct packed {
		logic       found;
		min_index_t min_index;
		logic       key_truncated;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/lmks_core.sv
// Per-item key compare and best-entry tracking for lexicographic min select.
// Holds the two key stores in one memory with a prefetched, bypassed read.
// Depends on lmks_pkg.
`default_nettype none

module lmks_core #(
	parameter int MAX_KEY_LEN = lmks_pkg::MAX_KEY_LEN_DEF,
	parameter int MAX_ENTRIES = lmks_pkg::MAX_ENTRIES_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                fire,
	input  lmks_pkg::item_t    item,
	input  wire  [7:0]         separator_byte,
	output logic               res_valid,
	output lmks_pkg::result_t  res
);

	localparam int LEN_W = $clog2(MAX_KEY_LEN + 1);
	localparam int AW    = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int DEPTH = 2 ** (AW + 1);

	logic [7:0]       mem [DEPTH];
	logic [7:0]       rd_q;

	logic             sel_q, sel_n;
	logic [LEN_W-1:0] best_len_q, best_len_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic [1:0]       st_q, st_n;
	logic             ended_q, ended_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [CNT_W-1:0] pos_q, pos_n;
	logic             have_q, have_n;
	logic             trunc_q, trunc_n;

	logic             cnt_room;
	logic             wr_en;
	logic [AW:0]      wr_addr;
	logic [AW:0]      rd_addr;

	assign cnt_room = cnt_q < CNT_W'(MAX_ENTRIES);
	assign wr_addr  = {~sel_q, len_q[AW-1:0]};
	assign rd_addr  = {sel_n, len_n[AW-1:0]};

	always_comb begin
		sel_n      = sel_q;
		best_len_n = best_len_q;
		len_n      = len_q;
		st_n       = st_q;
		ended_n    = ended_q;
		cnt_n      = cnt_q;
		pos_n      = pos_q;
		have_n     = have_q;
		trunc_n    = trunc_q;
		wr_en      = 1'b0;
		res_valid  = 1'b0;
		res        = '0;
		if (fire) begin
			if (item.missing_entry) begin
				if (cnt_room)
					cnt_n = CNT_W'(cnt_q + 1'b1);
				len_n   = '0;
				st_n    = lmks_pkg::CMP_EQUAL;
				ended_n = 1'b0;
			end else begin
				if (item.byte_valid && !ended_q && cnt_room) begin
					if (separator_byte != 8'd0 && item.key_byte == separator_byte) begin
						ended_n = 1'b1;
					end else if (len_q >= LEN_W'(MAX_KEY_LEN)) begin
						trunc_n = 1'b1;
					end else begin
						wr_en = 1'b1;
						if (have_q && st_q == lmks_pkg::CMP_EQUAL && len_q < best_len_q) begin
							if (item.key_byte < rd_q)
								st_n = lmks_pkg::CMP_LESS;
							else if (item.key_byte > rd_q)
								st_n = lmks_pkg::CMP_GREATER;
						end
						len_n = LEN_W'(len_q + 1'b1);
					end
				end
				if (item.end_of_string || item.end_of_set) begin
					if (cnt_room) begin
						cnt_n = CNT_W'(cnt_q + 1'b1);
						if (!have_q || st_n == lmks_pkg::CMP_LESS ||
						    (st_n == lmks_pkg::CMP_EQUAL && len_n < best_len_q)) begin
							have_n     = 1'b1;
							sel_n      = ~sel_q;
							best_len_n = len_n;
							pos_n      = cnt_n;
						end
					end
					len_n   = '0;
					st_n    = lmks_pkg::CMP_EQUAL;
					ended_n = 1'b0;
				end
			end
			if (item.end_of_set) begin
				res_valid = 1'b1;
				// a lone entry answers position one even when missing
				if (cnt_n == CNT_W'(1)) begin
					res.found     = 1'b1;
					res.min_index = lmks_pkg::min_index_t'(1);
				end else if (have_n) begin
					res.found     = 1'b1;
					res.min_index = lmks_pkg::min_index_t'(pos_n);
				end
				res.key_truncated = trunc_n;
				sel_n      = 1'b0;
				best_len_n = '0;
				cnt_n      = '0;
				pos_n      = '0;
				have_n     = 1'b0;
				trunc_n    = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q      <= 1'b0;
			best_len_q <= '0;
			len_q      <= '0;
			st_q       <= lmks_pkg::CMP_EQUAL;
			ended_q    <= 1'b0;
			cnt_q      <= '0;
			pos_q      <= '0;
			have_q     <= 1'b0;
			trunc_q    <= 1'b0;
		end else begin
			sel_q      <= sel_n;
			best_len_q <= best_len_n;
			len_q      <= len_n;
			st_q       <= st_n;
			ended_q    <= ended_n;
			cnt_q      <= cnt_n;
			pos_q      <= pos_n;
			have_q     <= have_n;
			trunc_q    <= trunc_n;
		end
	end

	// best-key byte for the next candidate position, with write bypass
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= item.key_byte;
		if (wr_en && wr_addr == rd_addr)
			rd_q <= item.key_byte;
		else
			rd_q <= mem[rd_addr];
	end

`ifndef NO_ASSERTIONS
	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!have_q |-> pos_q == '0) else $error("best position set without a best key");
	a_pos_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= cnt_q) else $error("best position beyond entry count");
	a_have_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> cnt_q != '0) else $error("best key with no entries counted");
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_KEY_LEN) && best_len_q <= LEN_W'(MAX_KEY_LEN))
		else $error("key length beyond store size");
	a_set_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> cnt_q == '0 && !have_q && !trunc_q)
		else $error("set state not cleared after answer");
`endif

endmodule

`default_nettype wire

FILE: rtl/lexicographic_min_key_select_top.sv
// Each request is held in the input register; its answer is registered with m_tvalid.
// Throughput: one request per cycle; an input register and a result register
// separate the sides, stalling only when an end of set meets a full result register.
// Reset: arst_n clears all control state and sets the separator to 0;
// the key store memory is not cleared.
// Top level of the lexicographic minimum key select block; depends on lmks_pkg, lmks_core.
`default_nettype none

module lexicographic_min_key_select_top #(
	parameter int MAX_KEY_LEN = lmks_pkg::MAX_KEY_LEN_DEF,
	parameter int MAX_ENTRIES = lmks_pkg::MAX_ENTRIES_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [lmks_pkg::IN_TDATA_W-1:0]    s_tdata,  // key_byte, end_of_string, zero pad
	input  wire  [1:0]                         s_tuser,  // byte_valid, missing_entry
	input  wire                                s_tlast,  // end_of_set
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [lmks_pkg::OUT_TDATA_W-1:0]   m_tdata,  // found, min_index, key_truncated, pad
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [7:0]                         cfg_data
);

	logic               in_valid_s1;
	lmks_pkg::item_t    item_s1;
	logic               core_fire;
	logic               res_valid;
	lmks_pkg::result_t  res;
	lmks_pkg::result_t  res_q;
	logic               m_tvalid_q;
	logic [7:0]         sep_q;

	assign cfg_ready = 1'b1;
	assign core_fire = in_valid_s1 && (!item_s1.end_of_set || !m_tvalid_q || m_tready);
	assign s_tready  = !in_valid_s1 || core_fire;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {5'd0, res_q.key_truncated, res_q.min_index, res_q.found};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q       <= 8'd0;
			in_valid_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_valid)
				sep_q <= cfg_data;
			if (s_tready)
				in_valid_s1 <= s_tvalid;
			if (res_valid)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.byte_valid    <= s_tuser[0];
			item_s1.key_byte      <= s_tdata[7:0];
			item_s1.end_of_string <= s_tdata[8];
			item_s1.missing_entry <= s_tuser[1];
			item_s1.end_of_set    <= s_tlast;
		end
		if (res_valid)
			res_q <= res;
	end

	lmks_core #(
		.MAX_KEY_LEN(MAX_KEY_LEN),
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (core_fire),
		.item          (item_s1),
		.separator_byte(sep_q),
		.res_valid     (res_valid),
		.res           (res)
	);

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for lexicographic_min_key_select_top: streams sets of strings,
// predicts the smallest-key position of each set and compares every answer.
// Depends on lmks_pkg and the top level only.
`default_nettype none

module testbench;

	localparam int KEY_LEN     = lmks_pkg::MAX_KEY_LEN_DEF;
	localparam int ENTRY_LIMIT = lmks_pkg::MAX_ENTRIES_DEF;
	localparam int IDLE_LIMIT  = 2000;
	localparam int IDLE_PCT    = 35;

	logic                             clk;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	logic [lmks_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
	logic [1:0]                       s_tuser   = '0;
	logic                             s_tlast   = 1'b0;
	logic                             m_tvalid;
	logic                             m_tready  = 1'b0;
	logic [lmks_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [7:0]                       cfg_data  = '0;

	lmks_pkg::item_t   pending_requests [$];
	lmks_pkg::result_t expected_answers [$];
	int      requests_sent  = 0;
	int      requests_taken = 0;
	int      answers_seen   = 0;
	int      sets_closed    = 0;
	int      separator_writes = 0;
	int      failures       = 0;
	int      idle_cycles    = 0;
	bit      steady         = 1'b0;

	// predicted state of the block
	logic [7:0] store_a [0:KEY_LEN-1];
	logic [7:0] store_b [0:KEY_LEN-1];
	bit         best_in_b;
	int         best_len;
	int         cand_len;
	logic [1:0] cmp_state;
	bit         key_done;
	int         entries;
	int         best_pos;
	bit         have_best;
	bit         trunc_seen;
	logic [7:0] separator = 8'h00;

	lexicographic_min_key_select_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function void clear_candidate();
		cand_len  = 0;
		cmp_state = lmks_pkg::CMP_EQUAL;
		key_done  = 1'b0;
	endfunction

	function void clear_set();
		clear_candidate();
		best_in_b  = 1'b0;
		best_len   = 0;
		entries    = 0;
		best_pos   = 0;
		have_best  = 1'b0;
		trunc_seen = 1'b0;
	endfunction

	function void take_key_byte(logic [7:0] b);
		logic [7:0] held;
		if (key_done || entries >= ENTRY_LIMIT)
			return;
		if (separator != 8'h00 && b == separator) begin
			key_done = 1'b1;
			return;
		end
		if (cand_len >= KEY_LEN) begin
			trunc_seen = 1'b1;
			return;
		end
		// candidate lives in the store not holding the best key
		if (best_in_b)
			store_a[cand_len] = b;
		else
			store_b[cand_len] = b;
		if (have_best && cmp_state == lmks_pkg::CMP_EQUAL && cand_len < best_len) begin
			held = best_in_b ? store_b[cand_len] : store_a[cand_len];
			if (b < held)
				cmp_state = lmks_pkg::CMP_LESS;
			else if (b > held)
				cmp_state = lmks_pkg::CMP_GREATER;
		end
		cand_len++;
	endfunction

	function void close_string();
		if (entries < ENTRY_LIMIT) begin
			entries++;
			if (!have_best || cmp_state == lmks_pkg::CMP_LESS ||
					(cmp_state == lmks_pkg::CMP_EQUAL && cand_len < best_len)) begin
				have_best = 1'b1;
				best_in_b = ~best_in_b;
				best_len  = cand_len;
				best_pos  = entries;
			end
		end
		clear_candidate();
	endfunction

	function void absorb_request(lmks_pkg::item_t it);
		lmks_pkg::result_t r;
		if (it.missing_entry) begin
			if (entries < ENTRY_LIMIT)
				entries++;
			clear_candidate();
		end else begin
			if (it.byte_valid)
				take_key_byte(it.key_byte);
			if (it.end_of_string || it.end_of_set)
				close_string();
		end
		if (it.end_of_set) begin
			if (entries == 1) begin
				r.found     = 1'b1;
				r.min_index = lmks_pkg::min_index_t'(1);
			end else if (have_best) begin
				r.found     = 1'b1;
				r.min_index = best_pos[lmks_pkg::MIN_INDEX_W-1:0];
			end else begin
				r.found     = 1'b0;
				r.min_index = '0;
			end
			r.key_truncated = trunc_seen;
			expected_answers.push_back(r);
			sets_closed++;
			clear_set();
		end
	endfunction

	initial clear_set();

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_requests
		lmks_pkg::item_t got;
		lmks_pkg::item_t nxt;
		bit    busy;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				got.byte_valid    = s_tuser[0];
				got.key_byte      = s_tdata[7:0];
				got.end_of_string = s_tdata[8];
				got.missing_entry = s_tuser[1];
				got.end_of_set    = s_tlast;
				absorb_request(got);
				requests_taken++;
				busy = 1'b0;
			end
			if (!busy && pending_requests.size() != 0 &&
					(steady || $urandom_range(99) >= IDLE_PCT)) begin
				nxt = pending_requests.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {{(lmks_pkg::IN_TDATA_W-9){1'b0}}, nxt.end_of_string,
					nxt.key_byte};
				s_tuser  <= {nxt.missing_entry, nxt.byte_valid};
				s_tlast  <= nxt.end_of_set;
			end else if (!busy) begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic note_failure(string msg);
		failures++;
		if (failures <= 10)
			$display("MISMATCH: %s", msg);
	endtask

	// answer monitor
	always @(posedge clk or negedge arst_n) begin : check_answers
		lmks_pkg::result_t want;
		logic       got_found;
		logic [16:0] got_index;
		logic       got_trunc;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_found = m_tdata[0];
				got_index = m_tdata[17:1];
				got_trunc = m_tdata[18];
				answers_seen++;
				if (expected_answers.size() == 0) begin
					note_failure($sformatf("unexpected answer found=%0d index=%0d trunc=%0d",
						got_found, got_index, got_trunc));
				end else begin
					want = expected_answers.pop_front();
					if (got_found !== want.found)
						note_failure($sformatf("answer %0d found exp %0d got %0d",
							answers_seen, want.found, got_found));
					if (got_index !== want.min_index)
						note_failure($sformatf("answer %0d min_index exp %0d got %0d",
							answers_seen, want.min_index, got_index));
					if (got_trunc !== want.key_truncated)
						note_failure($sformatf("answer %0d key_truncated exp %0d got %0d",
							answers_seen, want.key_truncated, got_trunc));
				end
			end
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout after %0d cycles without progress", IDLE_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic push_request(bit bv, logic [7:0] b, bit eos, bit miss, bit eoset);
		lmks_pkg::item_t it;
		it.byte_valid    = bv;
		it.key_byte      = b;
		it.end_of_string = eos;
		it.missing_entry = miss;
		it.end_of_set    = eoset;
		pending_requests.push_back(it);
		requests_sent++;
	endtask

	task automatic push_string(int len, bit last, logic [7:0] base, int span);
		logic [7:0] b;
		bit         on_byte;
		bit         eos_fin;
		on_byte = (len != 0) && ($urandom_range(2) == 0);
		// a set may also be closed by end_of_set alone
		eos_fin = last ? bit'($urandom_range(1)) : 1'b1;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(11) == 0)
				b = separator;
			else if (span >= 255)
				b = 8'($urandom_range(255));
			else
				b = base + 8'($urandom_range(span));
			if (on_byte && i == len - 1)
				push_request(1'b1, b, eos_fin, 1'b0, last);
			else
				push_request(1'b1, b, 1'b0, 1'b0, 1'b0);
		end
		if (!on_byte)
			push_request(1'b0, 8'($urandom_range(255)), eos_fin, 1'b0, last);
	endtask

	task automatic push_missing(bit last);
		int n;
		if ($urandom_range(2) == 0) begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++)
				push_request(1'b1, 8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
		end
		push_request(bit'($urandom_range(1)), 8'($urandom_range(255)),
			bit'($urandom_range(1)), 1'b1, last);
	endtask

	task automatic push_set();
		int         n;
		int         span;
		int         r;
		int         len;
		logic [7:0] base;
		n    = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
		base = 8'($urandom_range(255));
		case ($urandom_range(3))
			0: span = 0;
			1: span = 1;
			2: span = 3;
			default: span = 255;
		endcase
		for (int e = 0; e < n; e++) begin
			if ($urandom_range(7) == 0) begin
				push_missing(e == n - 1);
			end else begin
				r = $urandom_range(99);
				if (r < 60)
					len = $urandom_range(0, 5);
				else if (r < 88)
					len = $urandom_range(6, 31);
				else
					len = $urandom_range(32, 40);
				push_string(len, e == n - 1, base, span);
			end
		end
	endtask

	task automatic push_noise_set();
		int k;
		k = $urandom_range(1, 6);
		for (int i = 0; i < k; i++)
			push_request(bit'($urandom_range(1)), 8'($urandom_range(255)),
				bit'($urandom_range(1)), bit'($urandom_range(1)), i == k - 1);
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (requests_taken != requests_sent || expected_answers.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_separator(logic [7:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		separator = v;
		separator_writes++;
	endtask

	initial begin : run_sequence
		logic [7:0] sep_plan [0:5];
		int         start;
		sep_plan[0] = 8'h2C;
		sep_plan[1] = 8'hFF;
		sep_plan[2] = 8'h01;
		sep_plan[3] = 8'h00;
		sep_plan[4] = 8'($urandom_range(255));
		sep_plan[5] = 8'($urandom_range(255));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// whole string is the key
		push_request(1'b0, 8'h00, 1'b1, 1'b0, 1'b1);      // lone empty string
		push_request(1'b1, 8'hA5, 1'b1, 1'b1, 1'b1);      // lone missing entry
		push_request(1'b0, 8'h00, 1'b0, 1'b1, 1'b0);      // all missing
		push_request(1'b0, 8'h00, 1'b0, 1'b1, 1'b1);
		push_request(1'b1, 8'hFF, 1'b1, 1'b0, 1'b0);      // byte extremes, end of set alone
		push_request(1'b1, 8'h00, 1'b0, 1'b0, 1'b1);
		push_request(1'b1, 8'h61, 1'b0, 1'b0, 1'b0);      // shorter prefix, missing mid string
		push_request(1'b1, 8'h62, 1'b1, 1'b0, 1'b0);
		push_request(1'b1, 8'h71, 1'b0, 1'b0, 1'b0);
		push_request(1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
		push_request(1'b1, 8'h61, 1'b1, 1'b0, 1'b1);
		push_request(1'b1, 8'h7A, 1'b1, 1'b0, 1'b0);      // tie keeps the earlier
		push_request(1'b1, 8'h7A, 1'b1, 1'b0, 1'b1);
		push_request(1'b1, 8'h10, 1'b0, 1'b0, 1'b0);      // separate end markers
		push_request(1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
		push_request(1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		push_request(1'b1, 8'h10, 1'b0, 1'b0, 1'b0);
		push_request(1'b1, 8'h05, 1'b0, 1'b0, 1'b0);
		push_request(1'b0, 8'h00, 1'b1, 1'b0, 1'b1);
		wait_idle();

		// keys cut at the separator
		write_separator(8'h2C);
		push_request(1'b1, 8'h62, 1'b0, 1'b0, 1'b0);
		push_request(1'b1, 8'h2C, 1'b0, 1'b0, 1'b0);
		push_request(1'b1, 8'h7A, 1'b1, 1'b0, 1'b0);
		push_request(1'b1, 8'h62, 1'b1, 1'b0, 1'b0);
		push_request(1'b1, 8'h61, 1'b0, 1'b0, 1'b0);
		push_request(1'b1, 8'h2C, 1'b0, 1'b0, 1'b0);
		push_request(1'b1, 8'h2C, 1'b0, 1'b0, 1'b0);
		push_request(1'b1, 8'h30, 1'b1, 1'b0, 1'b1);
		wait_idle();

		// random sets, sender pauses for all answers between phases
		for (int p = 0; p < 6; p++) begin
			write_separator(sep_plan[p]);
			steady = (p == 1);
			start  = requests_sent;
			while (requests_sent - start < 100) begin
				if ($urandom_range(19) == 0)
					push_noise_set();
				else
					push_set();
			end
			wait_idle();
		end
		steady = 1'b0;
		repeat (8) @(posedge clk);

		if (expected_answers.size() != 0)
			note_failure($sformatf("%0d answers never arrived", expected_answers.size()));
		$display("Covered %0d requests in %0d sets, %0d answers checked, %0d separator writes,",
			requests_taken, sets_closed, answers_seen, separator_writes);
		$display("including byte extremes, missing entries, separators and long keys.");
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: lexicographic_min_key_select_top.f
rtl/lmks_pkg.sv
rtl/lmks_core.sv
rtl/lexicographic_min_key_select_top.sv
test/testbench.sv
